>>> sv/buddy_block_allocate_top_macros.svh
`ifndef BUDDY_BLOCK_ALLOCATE_TOP_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATE_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/bba_pkg.sv
`default_nettype none

package bba_pkg;

  localparam int MAX_POOL_BYTES_DEF = 65536;
  localparam int ALIGN_BYTES_DEF    = 16;
  localparam int HEADER_BYTES_DEF   = 16;
  localparam int GRANULE_BYTES_DEF  = 32;

  localparam int REQ_W           = 16;
  localparam int LOG_W           = 5;
  localparam int POOL_LOG2_RESET = 16;
  localparam int MIN_POOL_LOG2   = 6;

  typedef struct packed {
    logic             granted;
    logic [REQ_W-1:0] block_offset;
    logic [REQ_W-1:0] payload_bytes;
  } bba_result_t;

  function automatic logic [LOG_W-1:0] sat_log2(input logic [LOG_W-1:0] v,
                                                input int lo, input int hi);
    logic [LOG_W-1:0] e;
    e = v;
    if (int'(e) < lo) e = LOG_W'(lo);
    if (int'(e) > hi) e = LOG_W'(hi);
    return e;
  endfunction

endpackage

`default_nettype wire

>>> sv/bba_ram.sv
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/bba_ctrl.sv
`default_nettype none

module bba_ctrl import bba_pkg::*; #(
  parameter int MAX_POOL_BYTES = MAX_POOL_BYTES_DEF,
  parameter int ALIGN_BYTES    = ALIGN_BYTES_DEF,
  parameter int HEADER_BYTES   = HEADER_BYTES_DEF,
  parameter int GRANULE_BYTES  = GRANULE_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             init_req,
  input  wire logic [LOG_W-1:0] pool_log2,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [REQ_W-1:0] request_bytes,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output bba_result_t           res
);

  localparam int LOG_HI = $clog2(MAX_POOL_BYTES + 1) - 1;
  localparam int DEPTH  = (MAX_POOL_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OFF_W  = LOG_HI + 1;
  localparam int NEED_W = REQ_W + 1;
  localparam int AW     = ((OFF_W > NEED_W) ? OFF_W : NEED_W) + 1;
  localparam int HDR_W  = LOG_W + 1;

  typedef struct packed {
    logic             used;
    logic [LOG_W-1:0] lg;
  } hdr_t;

  typedef enum logic [4:0] {
    S_INIT  = 5'b00001,
    S_IDLE  = 5'b00010,
    S_WALK  = 5'b00100,
    S_SPLIT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [AW-1:0]     off, off_next;
  logic [NEED_W-1:0] need, need_next;
  logic [LOG_W-1:0]  lg, lg_next;
  bba_result_t       res_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  hdr_t              ram_wdata, hdr;
  logic [HDR_W-1:0]  ram_rdata;

  logic [NEED_W-1:0] req_ext, need_in;
  logic [LOG_W-1:0]  lg_rd;
  logic [AW-1:0]     total, payload, next_off, pool;
  logic [AW-1:0]     cur_total, half, cur_payload;
  logic              fit, can_split;
  logic [31:0]       off_wide, pay_wide;

  function automatic logic [ADDR_W-1:0] to_idx(input logic [AW-1:0] x);
    return ADDR_W'(x / GRANULE_BYTES);
  endfunction

  bba_ram #(
    .WIDTH (HDR_W),
    .DEPTH (DEPTH)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign hdr = hdr_t'(ram_rdata);

  always_comb begin
    req_ext = (request_bytes == '0) ? NEED_W'(1) : NEED_W'(request_bytes);
    need_in = NEED_W'(((req_ext + NEED_W'(ALIGN_BYTES - 1)) / ALIGN_BYTES) * ALIGN_BYTES);

    lg_rd    = (hdr.lg > LOG_W'(LOG_HI)) ? LOG_W'(LOG_HI) : hdr.lg;
    total    = AW'(1) << lg_rd;
    payload  = (total > AW'(HEADER_BYTES)) ? total - AW'(HEADER_BYTES) : '0;
    fit      = !hdr.used && (payload >= AW'(need));
    next_off = off + total;
    pool     = AW'(1) << pool_log2;

    cur_total   = AW'(1) << lg;
    half        = cur_total >> 1;
    cur_payload = (cur_total > AW'(HEADER_BYTES)) ? cur_total - AW'(HEADER_BYTES) : '0;
    can_split   = (lg != '0) && (half >= AW'(GRANULE_BYTES)) &&
                  (half >= AW'(HEADER_BYTES)) &&
                  ((half - AW'(HEADER_BYTES)) >= AW'(need));
    off_wide    = 32'(off);
    pay_wide    = 32'(cur_payload);
  end

  always_comb begin
    state_next = state;
    off_next   = off;
    need_next  = need;
    lg_next    = lg;
    res_next   = res;
    ram_we     = 1'b0;
    ram_waddr  = to_idx(off);
    ram_wdata  = '0;
    ram_raddr  = to_idx(off);
    in_ready   = 1'b0;
    res_valid  = 1'b0;

    unique case (state)
      S_INIT: begin
        ram_we        = 1'b1;
        ram_waddr     = '0;
        ram_wdata.lg  = pool_log2;
        state_next    = S_IDLE;
      end
      S_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = '0;
        if (in_valid) begin
          need_next  = need_in;
          off_next   = '0;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (fit) begin
          lg_next    = lg_rd;
          state_next = S_SPLIT;
        end else if (next_off >= pool) begin
          res_next   = '0;
          state_next = S_DONE;
        end else begin
          off_next  = next_off;
          ram_raddr = to_idx(next_off);
        end
      end
      S_SPLIT: begin
        ram_we = 1'b1;
        if (can_split) begin
          ram_waddr    = to_idx(off + half);
          ram_wdata.lg = lg - LOG_W'(1);
          lg_next      = lg - LOG_W'(1);
        end else begin
          ram_wdata.used         = 1'b1;
          ram_wdata.lg           = lg;
          res_next.granted       = 1'b1;
          res_next.block_offset  = off_wide[REQ_W-1:0];
          res_next.payload_bytes = pay_wide[REQ_W-1:0];
          state_next             = S_DONE;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase

    if (init_req) state_next = S_INIT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
    off  <= off_next;
    need <= need_next;
    lg   <= lg_next;
    res  <= res_next;
  end

endmodule

`default_nettype wire

>>> sv/buddy_block_allocate_top.sv
// First-fit power-of-two block allocator. Each request walks the block headers
// from offset 0, reading one header per cycle from a single header RAM, then
// halves the found block one buddy header write per cycle and marks it used in
// one more write. A granted item passes from the walk state through the split
// state to the done state; a failed one goes from the walk state straight to
// done. The next request is taken only once the result has left the done state
// and the block is back in its idle state. The single RAM write port, its
// registered read and the idle state between items set this pace. One item is
// in work at a time. A finished result waits in the output register while the
// next request is taken. After reset or a write of pool_size_log2 the block
// writes the root header in its init state before it takes a request.
`default_nettype none

`include "buddy_block_allocate_top_macros.svh"

module buddy_block_allocate_top import bba_pkg::*; #(
  parameter int MAX_POOL_BYTES = MAX_POOL_BYTES_DEF,
  parameter int ALIGN_BYTES    = ALIGN_BYTES_DEF,
  parameter int HEADER_BYTES   = HEADER_BYTES_DEF,
  parameter int GRANULE_BYTES  = GRANULE_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write_en,
  input  wire logic [LOG_W-1:0] pool_size_log2,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [REQ_W-1:0] request_bytes,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  granted,
  output logic      [REQ_W-1:0] block_offset,
  output logic      [REQ_W-1:0] payload_bytes
);

  localparam int LOG_HI = $clog2(MAX_POOL_BYTES + 1) - 1;
  localparam int LOG_LO = ($clog2(GRANULE_BYTES) > MIN_POOL_LOG2) ?
                          $clog2(GRANULE_BYTES) : MIN_POOL_LOG2;

  logic [LOG_W-1:0] pool_log2;
  logic             res_valid, res_ready;
  bba_result_t      res;

  bba_ctrl #(
    .MAX_POOL_BYTES (MAX_POOL_BYTES),
    .ALIGN_BYTES    (ALIGN_BYTES),
    .HEADER_BYTES   (HEADER_BYTES),
    .GRANULE_BYTES  (GRANULE_BYTES)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .init_req      (cfg_write_en),
    .pool_log2     (pool_log2),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .request_bytes (request_bytes),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_log2 <= sat_log2(LOG_W'(POOL_LOG2_RESET), LOG_LO, LOG_HI);
      out_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        pool_log2 <= sat_log2(pool_size_log2, LOG_LO, LOG_HI);
      end
      if (res_valid && res_ready) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (res_valid && res_ready) begin
      granted       <= res.granted;
      block_offset  <= res.block_offset;
      payload_bytes <= res.payload_bytes;
    end
  end

  `BBA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
  `BBA_ASSERT_NEXT(a_init_after_cfg, cfg_write_en, !in_ready, "request taken during pool init")
  `BBA_ASSERT_IMP(a_fail_zero, out_valid && !granted, block_offset == '0 && payload_bytes == '0, "nonzero fields on failed transaction")

endmodule

`default_nettype wire
